[rtl/ssf_pkg.sv]
`default_nettype none
// Shared constants and types of the state-space filter step.
package ssf_pkg;

   // Model size and storage geometry
   localparam int MAX_ORDER  = 8;
   localparam int DIM        = MAX_ORDER + 1;
   localparam int COEF_DEPTH = DIM * DIM;
   localparam int ADDR_W     = $clog2(COEF_DEPTH);
   localparam int ROW_W      = $clog2(DIM);
   localparam int IDX_W      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   // Field widths
   localparam int OP_W       = 2;
   localparam int CIDX_W     = 4;
   localparam int ORDER_W    = 4;
   localparam int COEF_W     = 32;
   localparam int SAMPLE_W   = 24;
   localparam int STATE_W    = 40;

   // Fixed-point arithmetic
   localparam int COEF_FRAC  = 27;
   localparam int U_SHIFT    = 8;                  // Q1.23 to Q9.31
   localparam int LO_W       = 16;                 // low operand slice, unsigned
   localparam int HI_W       = STATE_W - LO_W;     // high operand slice, signed
   localparam int MUL_B_W    = HI_W + 1;
   localparam int PROD_W     = COEF_W + MUL_B_W;
   localparam int SUM_W      = PROD_W + LO_W + 1;
   localparam int TERM_W     = SUM_W - COEF_FRAC;
   localparam int ACC_W      = 50;
   localparam int Y_W        = ACC_W - U_SHIFT;

   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] Y_BIAS     = ACC_W'(1) << (U_SHIFT - 1);

   // Operation codes
   localparam logic [OP_W-1:0] OP_FILTER      = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_COEF  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_STATE = 2'd2;

   // One multiply-accumulate term on its way through the shared unit
   typedef struct packed {
      logic                 valid;
      logic                 last;    // closes a matrix row
      logic [ROW_W-1:0]     row;
   } tag_type;

   // Exact row sum handed back to the sequencer
   typedef struct packed {
      logic                    valid;
      logic [ROW_W-1:0]        row;
      logic signed [ACC_W-1:0] sum;
   } res_type;

endpackage
`default_nettype wire

[rtl/ssf_coef_store.sv]
`default_nettype none
// Coefficient memory of the matrix [Ad Bd; Cd Dd] with per-entry valid bits.
module ssf_coef_store (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  wr_en,
   input  wire        [ssf_pkg::ADDR_W-1:0]     wr_addr,
   input  wire signed [ssf_pkg::COEF_W-1:0]     wr_data,
   input  wire        [ssf_pkg::ADDR_W-1:0]     rd_addr,
   output logic signed [ssf_pkg::COEF_W-1:0]    rd_coef
);

   logic signed [ssf_pkg::COEF_W-1:0] coef_mem [ssf_pkg::COEF_DEPTH];
   logic        [ssf_pkg::COEF_DEPTH-1:0] valid_ff, valid_in;
   logic signed [ssf_pkg::COEF_W-1:0] rd_data_ff;
   logic                              rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= coef_mem[rd_addr];
   end

   // an entry never written reads as zero
   assign rd_coef = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

[rtl/ssf_mac.sv]
`default_nettype none
// Shared multiply, round and accumulate unit of the state-space filter.
module ssf_mac (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire ssf_pkg::tag_type                issue,
   input  wire signed [ssf_pkg::STATE_W-1:0]    issue_opnd,
   input  wire signed [ssf_pkg::COEF_W-1:0]     coef,
   output ssf_pkg::res_type                     res,
   output logic                                 busy
);

   ssf_pkg::tag_type tag0_ff, tag1_ff, tag2_ff, tag3_ff;
   ssf_pkg::res_type res_ff, res_in;

   logic signed [ssf_pkg::STATE_W-1:0] opnd_ff;
   logic signed [ssf_pkg::COEF_W-1:0]  coef_ff;
   logic        [ssf_pkg::LO_W-1:0]    lo_ff;
   logic signed [ssf_pkg::PROD_W-1:0]  prod_hi_ff, prod_lo_ff;
   logic signed [ssf_pkg::TERM_W-1:0]  term_ff, term_in;
   logic signed [ssf_pkg::ACC_W-1:0]   acc_ff, acc_in, acc_sum;

   logic signed [ssf_pkg::COEF_W-1:0]  mul_a;
   logic signed [ssf_pkg::MUL_B_W-1:0] mul_b;
   logic signed [ssf_pkg::PROD_W-1:0]  product;
   logic signed [ssf_pkg::SUM_W-1:0]   wide;

   // the one multiplier: high operand slice, then low slice of the same term
   always_comb begin
      if (tag0_ff.valid) begin
         mul_a = coef;
         mul_b = ssf_pkg::MUL_B_W'(signed'(opnd_ff[ssf_pkg::STATE_W-1:ssf_pkg::LO_W]));
      end else begin
         mul_a = coef_ff;
         mul_b = signed'({1'b0, ssf_pkg::HI_W'(lo_ff)});
      end
      product = mul_a * mul_b;
   end

   // recombine slices, round to 31 fraction bits, then accumulate
   always_comb begin
      wide    = ssf_pkg::SUM_W'(signed'({prod_hi_ff, {ssf_pkg::LO_W{1'b0}}}))
              + ssf_pkg::SUM_W'(prod_lo_ff) + ssf_pkg::ROUND_BIAS;
      term_in = wide[ssf_pkg::SUM_W-1:ssf_pkg::COEF_FRAC];
      acc_sum = acc_ff + ssf_pkg::ACC_W'(term_ff);
      acc_in  = acc_ff;
      res_in  = '0;
      if (tag3_ff.valid) begin
         if (tag3_ff.last) begin
            acc_in       = '0;
            res_in.valid = 1'b1;
            res_in.row   = tag3_ff.row;
            res_in.sum   = acc_sum;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         res_ff  <= '0;
         acc_ff  <= '0;
      end else begin
         tag0_ff <= issue;
         tag1_ff <= tag0_ff;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         res_ff  <= res_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         opnd_ff <= issue_opnd;
      end
      if (tag0_ff.valid) begin
         prod_hi_ff <= product;
         coef_ff    <= coef;
         lo_ff      <= opnd_ff[ssf_pkg::LO_W-1:0];
      end
      if (tag1_ff.valid) begin
         prod_lo_ff <= product;
      end
      term_ff <= term_in;
   end

   assign res  = res_ff;
   assign busy = tag0_ff.valid | tag1_ff.valid | tag2_ff.valid | tag3_ff.valid | res_ff.valid;

`ifndef SYNTHESIS
   a_mul_share: assert property (@(posedge clock) disable iff (reset)
      !(tag0_ff.valid && tag1_ff.valid))
      else $error("multiplier claimed by two terms at once");
   a_low_follows: assert property (@(posedge clock) disable iff (reset)
      tag0_ff.valid |=> tag1_ff.valid)
      else $error("low slice product did not follow high slice");
   a_row_close: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> $past(tag3_ff.valid && tag3_ff.last))
      else $error("row sum released without closing term");
`endif

endmodule
`default_nettype wire

[rtl/state_space_filter_step.sv]
`default_nettype none
// Top level of the state-space filter step: handshake, sequencer and state vector.
//
// Single-input single-output discrete state-space filter. A filter word
// (operation 0) returns one result word y = Cd*x + Dd*u, computed from the old
// state, and then replaces the state by x = Ad*x + Bd*u; coefficients are Q5.27,
// samples Q1.23, the state Q9.31 in 40 bits. Every product is rounded to 31
// fraction bits, the row sums are exact, y is rounded and clipped to Q1.23 and
// each new state value is clipped to 40 bits; rsp_saturated flags any clipping.
// A write-coefficient word (operation 1) stores one entry of [Ad Bd; Cd Dd], row
// and column 8 being the output row and input column; an out-of-range index is
// dropped. A clear word (operation 2) zeroes the state; operation 3 is ignored.
// Neither of these returns a word. The coefficient store reads as zero after
// reset. One filter word with n states in use (the system order register, 0
// taken as 1 and values above 8 as 8) needs (n+1)^2 multiply-accumulate terms;
// a single 32x25 multiplier handles each term in two passes (high and low slice
// of the state operand), so the sequencer issues a term only while its phase
// bit is low. The result word enters the output register once every row has been
// issued and the multiply-accumulate unit has drained; req_stall is held high
// from acceptance until then. A finished result waits in the output register and
// does not block the next word unless the following filter result is ready first.
module state_space_filter_step (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire        [ssf_pkg::OP_W-1:0]       req_operation,
   input  wire signed [ssf_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  wire        [ssf_pkg::CIDX_W-1:0]     req_coef_row,
   input  wire        [ssf_pkg::CIDX_W-1:0]     req_coef_col,
   input  wire signed [ssf_pkg::COEF_W-1:0]     req_coef_value,
   // response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [ssf_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                 rsp_saturated,
   // system order register
   input  wire                                  csr_write_en,
   input  wire        [ssf_pkg::ORDER_W-1:0]    csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } fsm_type;

   fsm_type fsm_ff, fsm_in;

   logic [ssf_pkg::ORDER_W-1:0]         order_ff, order_in;
   logic signed [ssf_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                                phase_ff, phase_in;
   logic [ssf_pkg::ROW_W-1:0]           row_ff, row_in;
   logic [ssf_pkg::ROW_W-1:0]           col_ff, col_in;
   logic                                sat_ff, sat_in;
   logic signed [ssf_pkg::SAMPLE_W-1:0] y_ff, y_in;
   logic signed [ssf_pkg::STATE_W-1:0]  xvec_ff [ssf_pkg::MAX_ORDER];
   logic signed [ssf_pkg::STATE_W-1:0]  xvec_in [ssf_pkg::MAX_ORDER];
   logic signed [ssf_pkg::STATE_W-1:0]  next_ff [ssf_pkg::MAX_ORDER];
   logic signed [ssf_pkg::STATE_W-1:0]  next_in [ssf_pkg::MAX_ORDER];
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [ssf_pkg::SAMPLE_W-1:0] rsp_sample_out_ff, rsp_sample_out_in;
   logic                                rsp_saturated_ff, rsp_saturated_in;

   logic                                req_accept;
   logic [ssf_pkg::ROW_W-1:0]           n_eff, n_last;
   logic                                col_last;
   ssf_pkg::tag_type                    issue;
   logic signed [ssf_pkg::STATE_W-1:0]  opnd;
   logic signed [ssf_pkg::STATE_W-1:0]  u_ext;
   logic                                cwr_en;
   logic [ssf_pkg::ADDR_W-1:0]          cwr_addr, crd_addr;
   logic signed [ssf_pkg::COEF_W-1:0]   coef;
   ssf_pkg::res_type                    res;
   logic                                mac_busy;
   logic signed [ssf_pkg::ACC_W-1:0]    y_round;
   logic signed [ssf_pkg::Y_W-1:0]      y_wide;
   logic                                y_fits, x_fits;
   logic signed [ssf_pkg::SAMPLE_W-1:0] y_clip;
   logic signed [ssf_pkg::STATE_W-1:0]  x_clip;

   function automatic logic [ssf_pkg::ADDR_W-1:0] coef_addr(
      input logic [ssf_pkg::ROW_W-1:0] r,
      input logic [ssf_pkg::ROW_W-1:0] c
   );
      return ssf_pkg::ADDR_W'(r) * ssf_pkg::ADDR_W'(ssf_pkg::DIM) + ssf_pkg::ADDR_W'(c);
   endfunction

   // Effective order: 0 is taken as 1, anything above the maximum as the maximum
   always_comb begin
      if (order_ff == '0) begin
         n_eff = ssf_pkg::ROW_W'(1);
      end else if (ssf_pkg::ROW_W'(order_ff) > ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER)) begin
         n_eff = ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER);
      end else begin
         n_eff = ssf_pkg::ROW_W'(order_ff);
      end
      n_last = n_eff - ssf_pkg::ROW_W'(1);
   end

   assign req_stall  = (fsm_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // input column never closes a row; the last state column does
   assign col_last = (col_ff != ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER)) && (col_ff == n_last);

   // u in state format, then the operand of the term being issued
   assign u_ext = {{(ssf_pkg::STATE_W - ssf_pkg::SAMPLE_W - ssf_pkg::U_SHIFT)
                    {sample_ff[ssf_pkg::SAMPLE_W-1]}},
                   sample_ff, {ssf_pkg::U_SHIFT{1'b0}}};
   assign opnd  = (col_ff == ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER)) ? u_ext
                : xvec_ff[col_ff[ssf_pkg::IDX_W-1:0]];

   assign crd_addr = coef_addr(row_ff, col_ff);
   assign cwr_addr = coef_addr(ssf_pkg::ROW_W'(req_coef_row), ssf_pkg::ROW_W'(req_coef_col));

   // Clip a finished row: output row to Q1.23 after rounding, state rows to 40 bits
   always_comb begin
      y_round = res.sum + ssf_pkg::Y_BIAS;
      y_wide  = y_round[ssf_pkg::ACC_W-1:ssf_pkg::U_SHIFT];
      y_fits  = (&y_wide[ssf_pkg::Y_W-1:ssf_pkg::SAMPLE_W-1])
              | (~|y_wide[ssf_pkg::Y_W-1:ssf_pkg::SAMPLE_W-1]);
      if (y_fits) begin
         y_clip = y_wide[ssf_pkg::SAMPLE_W-1:0];
      end else if (y_wide[ssf_pkg::Y_W-1]) begin
         y_clip = {1'b1, {(ssf_pkg::SAMPLE_W-1){1'b0}}};
      end else begin
         y_clip = {1'b0, {(ssf_pkg::SAMPLE_W-1){1'b1}}};
      end
      x_fits  = (&res.sum[ssf_pkg::ACC_W-1:ssf_pkg::STATE_W-1])
              | (~|res.sum[ssf_pkg::ACC_W-1:ssf_pkg::STATE_W-1]);
      if (x_fits) begin
         x_clip = res.sum[ssf_pkg::STATE_W-1:0];
      end else if (res.sum[ssf_pkg::ACC_W-1]) begin
         x_clip = {1'b1, {(ssf_pkg::STATE_W-1){1'b0}}};
      end else begin
         x_clip = {1'b0, {(ssf_pkg::STATE_W-1){1'b1}}};
      end
   end

   // Sequencer and handshake
   always_comb begin
      fsm_in            = fsm_ff;
      order_in          = order_ff;
      sample_in         = sample_ff;
      phase_in          = phase_ff;
      row_in            = row_ff;
      col_in            = col_ff;
      sat_in            = sat_ff;
      y_in              = y_ff;
      xvec_in           = xvec_ff;
      next_in           = next_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_sample_out_in = rsp_sample_out_ff;
      rsp_saturated_in  = rsp_saturated_ff;
      issue             = '0;
      cwr_en            = 1'b0;

      if (csr_write_en) begin
         order_in = csr_write_data;
      end

      // drop the response word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // store a finished row
      if (res.valid) begin
         if (res.row == ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER)) begin
            y_in   = y_clip;
            sat_in = sat_in | !y_fits;
         end else begin
            next_in[res.row[ssf_pkg::IDX_W-1:0]] = x_clip;
            sat_in = sat_in | !x_fits;
         end
      end

      case (fsm_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_operation)
                  ssf_pkg::OP_FILTER: begin
                     sample_in = req_sample_in;
                     sat_in    = 1'b0;
                     row_in    = ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER);
                     col_in    = ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER);
                     phase_in  = 1'b0;
                     fsm_in    = ST_RUN;
                  end
                  ssf_pkg::OP_WRITE_COEF: begin
                     cwr_en = (req_coef_row <= ssf_pkg::CIDX_W'(ssf_pkg::MAX_ORDER))
                           && (req_coef_col <= ssf_pkg::CIDX_W'(ssf_pkg::MAX_ORDER));
                  end
                  ssf_pkg::OP_CLEAR_STATE: begin
                     for (int i = 0; i < ssf_pkg::MAX_ORDER; i++) begin
                        xvec_in[i] = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            // issue a term only while the phase bit is low: output row first, input column first
            phase_in = !phase_ff;
            if (!phase_ff) begin
               issue.valid = 1'b1;
               issue.last  = col_last;
               issue.row   = row_ff;
               if (col_ff == ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER)) begin
                  col_in = '0;
               end else if (col_last) begin
                  col_in = ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER);
                  if (row_ff == ssf_pkg::ROW_W'(ssf_pkg::MAX_ORDER)) begin
                     row_in = '0;
                  end else if (row_ff == n_last) begin
                     fsm_in = ST_DRAIN;
                  end else begin
                     row_in = row_ff + ssf_pkg::ROW_W'(1);
                  end
               end else begin
                  col_in = col_ff + ssf_pkg::ROW_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               fsm_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free, then commit the new state
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_sample_out_in = y_ff;
               rsp_saturated_in  = sat_ff;
               for (int i = 0; i < ssf_pkg::MAX_ORDER; i++) begin
                  if (ssf_pkg::ROW_W'(i) < n_eff) begin
                     xvec_in[i] = next_ff[i];
                  end
               end
               fsm_in = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         order_ff     <= ssf_pkg::ORDER_W'(1);
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         for (int i = 0; i < ssf_pkg::MAX_ORDER; i++) begin
            xvec_ff[i] <= '0;
         end
      end else begin
         fsm_ff       <= fsm_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         xvec_ff      <= xvec_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff         <= sample_in;
      row_ff            <= row_in;
      col_ff            <= col_in;
      sat_ff            <= sat_in;
      y_ff              <= y_in;
      next_ff           <= next_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
      rsp_saturated_ff  <= rsp_saturated_in;
   end

   ssf_coef_store u_coef_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cwr_en),
      .wr_addr (cwr_addr),
      .wr_data (req_coef_value),
      .rd_addr (crd_addr),
      .rd_coef (coef)
   );

   ssf_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .issue_opnd (opnd),
      .coef       (coef),
      .res        (res),
      .busy       (mac_busy)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_saturated  = rsp_saturated_ff;

`ifndef SYNTHESIS
   a_busy_not_idle: assert property (@(posedge clock) disable iff (reset)
      mac_busy |-> fsm_ff != ST_IDLE)
      else $error("multiply-accumulate unit busy while idle");
   a_issue_spacing: assert property (@(posedge clock) disable iff (reset)
      issue.valid |=> !issue.valid)
      else $error("terms issued in consecutive cycles");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fsm_ff == ST_DONE))
      else $error("response word raised outside completion");
`endif

endmodule
`default_nettype wire
